// ===== rtl/gpfw_pkg.sv =====
// shared types, constants and glyph font for the glyph page framebuffer writer
package gpfw_pkg;

    // default geometry of the display store
    localparam int PAGE_COUNT_DEF   = 8;
    localparam int COLUMN_COUNT_DEF = 128;

    // fixed geometry of glyphs and flush blocks
    localparam int BLOCK_BYTES = 16;
    localparam int GLYPH_WIDTH = 5;
    localparam int BYTE_IDX_W  = $clog2(BLOCK_BYTES);

    // bus constants
    localparam logic [6:0] DEV_ADDR_RESET = 7'h3C;
    localparam logic [7:0] CMD_PAGE_BASE  = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW    = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH   = 8'h10;

    // request command codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_CURSOR = 2'd1;
    localparam logic [1:0] OP_PUT    = 2'd2;
    localparam logic [1:0] OP_FLUSH  = 2'd3;

    // index of the command transaction within a flush header
    localparam logic [1:0] HDR_PAGE     = 2'd0;
    localparam logic [1:0] HDR_COL_LOW  = 2'd1;
    localparam logic [1:0] HDR_COL_HIGH = 2'd2;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW,
        ST_HDR,
        ST_READ,
        ST_WAIT,
        ST_EMIT
    } fsm_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic latch;
        logic set_cursor;
        logic draw_step;
        logic flush_start;
        logic hdr_load;
        logic rd_step;
        logic data_load;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic draw_ok;
        logic draw_last;
        logic page_ok;
        logic hdr_last;
        logic byte_last;
        logic blk_last;
        logic out_free;
    } dp_status_t;

    // one column byte of the 5x7 font, after folding lower case to upper
    function automatic logic [7:0] glyph_column(input logic [7:0] ch, input logic [2:0] idx);
        logic [7:0]  up;
        logic [39:0] g;
        up = ch;
        if (ch >= 8'h61 && ch <= 8'h7A) begin
            up = ch - 8'h20;
        end
        // column 0 sits in bits 7:0
        case (up)
            8'h30: g = 40'h3E_45_49_51_3E;
            8'h31: g = 40'h00_40_7F_42_00;
            8'h32: g = 40'h46_49_49_51_62;
            8'h33: g = 40'h36_49_49_49_22;
            8'h34: g = 40'h10_7F_12_14_18;
            8'h35: g = 40'h31_49_49_49_2F;
            8'h36: g = 40'h32_49_49_49_3E;
            8'h37: g = 40'h03_05_09_71_01;
            8'h38: g = 40'h36_49_49_49_36;
            8'h39: g = 40'h3E_49_49_49_26;
            8'h41: g = 40'h7E_11_11_11_7E;
            8'h42: g = 40'h36_49_49_49_7F;
            8'h43: g = 40'h22_41_41_41_3E;
            8'h44: g = 40'h1C_22_41_41_7F;
            8'h45: g = 40'h41_49_49_49_7F;
            8'h46: g = 40'h01_09_09_09_7F;
            8'h47: g = 40'h7A_49_49_41_3E;
            8'h48: g = 40'h7F_08_08_08_7F;
            8'h49: g = 40'h00_41_7F_41_00;
            8'h4A: g = 40'h01_3F_41_40_20;
            8'h4B: g = 40'h41_22_14_08_7F;
            8'h4C: g = 40'h40_40_40_40_7F;
            8'h4D: g = 40'h7F_02_0C_02_7F;
            8'h4E: g = 40'h7F_10_08_04_7F;
            8'h4F: g = 40'h3E_41_41_41_3E;
            8'h50: g = 40'h06_09_09_09_7F;
            8'h51: g = 40'h5E_21_51_41_3E;
            8'h52: g = 40'h46_29_19_09_7F;
            8'h53: g = 40'h31_49_49_49_46;
            8'h54: g = 40'h01_01_7F_01_01;
            8'h55: g = 40'h3F_40_40_40_3F;
            8'h56: g = 40'h1F_20_40_20_1F;
            8'h57: g = 40'h7F_20_18_20_7F;
            8'h58: g = 40'h63_14_08_14_63;
            8'h59: g = 40'h07_08_70_08_07;
            8'h5A: g = 40'h43_45_49_51_61;
            8'h3A: g = 40'h00_00_36_36_00;
            8'h2E: g = 40'h00_00_60_40_00;
            8'h2D: g = 40'h08_08_08_08_08;
            8'h2F: g = 40'h02_04_08_10_20;
            8'h2B: g = 40'h08_08_3E_08_08;
            default: g = 40'h0;
        endcase
        case (idx)
            3'd0:    glyph_column = g[7:0];
            3'd1:    glyph_column = g[15:8];
            3'd2:    glyph_column = g[23:16];
            3'd3:    glyph_column = g[31:24];
            3'd4:    glyph_column = g[39:32];
            default: glyph_column = 8'h00;
        endcase
    endfunction

endpackage

// ===== rtl/gpfw_ctrl.sv =====
// controller state machine sequencing clear, draw and flush
module gpfw_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_command,
    input  gpfw_pkg::dp_status_t sts,
    output gpfw_pkg::ctrl_cmd_t  cmd
);
    import gpfw_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // state register, reset starts the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch = 1'b1;
                    case (s_command)
                        OP_CLEAR: begin
                            state_next = ST_CLEAR;
                        end
                        OP_CURSOR: begin
                            cmd.set_cursor = 1'b1;
                        end
                        OP_PUT: begin
                            if (sts.draw_ok) begin
                                state_next = ST_DRAW;
                            end
                        end
                        OP_FLUSH: begin
                            if (sts.page_ok) begin
                                cmd.flush_start = 1'b1;
                                state_next      = ST_HDR;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DRAW: begin
                cmd.draw_step = 1'b1;
                if (sts.draw_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_HDR: begin
                if (sts.out_free) begin
                    cmd.hdr_load = 1'b1;
                    if (sts.hdr_last) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_step = 1'b1;
                if (sts.byte_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.data_load = 1'b1;
                    state_next    = sts.blk_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // store port is used by at most one operation per cycle
    a_one_store_op: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clr_step, cmd.draw_step, cmd.rd_step}))
        else $error("store used by more than one operation");

    // no request is taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("request taken while clearing");

    // output register is only loaded when it can take a transaction
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.hdr_load || cmd.data_load) |-> sts.out_free)
        else $error("output register overwritten");

    // an in-range put character starts drawing in the next cycle
    a_put_draws: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_command == OP_PUT && sts.draw_ok)
            |=> (state_reg == ST_DRAW))
        else $error("put character did not start drawing");

endmodule

// ===== rtl/gpfw_datapath.sv =====
// datapath: display store, cursor, glyph writer, block gather and output register
module gpfw_datapath #(
    parameter int PAGE_COUNT   = gpfw_pkg::PAGE_COUNT_DEF,
    parameter int COLUMN_COUNT = gpfw_pkg::COLUMN_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gpfw_pkg::ctrl_cmd_t  cmd,
    output gpfw_pkg::dp_status_t sts,
    input  logic [3:0]           s_page,
    input  logic [7:0]           s_column,
    input  logic [7:0]           s_char_code,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [6:0]           cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [6:0]           m_bus_address,
    output logic                 m_is_data,
    output logic [7:0]           m_command_byte,
    output logic [63:0]          m_data_low,
    output logic [63:0]          m_data_high,
    output logic                 m_last
);
    import gpfw_pkg::*;

    localparam int PG_W    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int COL_W   = $clog2(COLUMN_COUNT);
    localparam int ADDR_W  = PG_W + COL_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int NBLK    = (COLUMN_COUNT + BLOCK_BYTES - 1) / BLOCK_BYTES;
    localparam int BLK_W   = (NBLK > 1) ? $clog2(NBLK) : 1;
    localparam int CIDX_W  = BLK_W + BYTE_IDX_W;
    localparam int DRAW_N  = GLYPH_WIDTH + 1;
    localparam int BLOCK_W = 8 * BLOCK_BYTES;

    localparam logic [4:0]        PAGE_LIMIT = 5'(PAGE_COUNT);
    localparam logic [8:0]        DRAW_LIMIT = 9'(COLUMN_COUNT - GLYPH_WIDTH);
    localparam logic [CIDX_W:0]   COL_LIMIT  = (CIDX_W + 1)'(COLUMN_COUNT);
    localparam logic [BLK_W-1:0]  BLK_LAST   = BLK_W'(NBLK - 1);
    localparam logic [2:0]        DRAW_LAST  = 3'(DRAW_N - 1);
    localparam logic [8:0]        DRAW_ADV   = 9'(DRAW_N);

    logic [7:0] mem [DEPTH];

    logic [6:0]            dev_addr_reg;
    logic [3:0]            cur_page_reg;
    logic [7:0]            cur_col_reg;
    logic [7:0]            char_reg;
    logic [3:0]            flush_page_reg;
    logic [ADDR_W-1:0]     clr_cnt_reg;
    logic [2:0]            draw_idx_reg;
    logic [1:0]            hdr_idx_reg;
    logic [BLK_W-1:0]      blk_reg;
    logic [BYTE_IDX_W-1:0] byte_reg;
    logic [7:0]            rdata_reg;
    logic                  rd_pend_reg;
    logic                  rd_in_reg;
    logic [BLOCK_W-1:0]    gather_reg;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic                  m_is_data_reg;
    logic [7:0]            m_cmd_reg;
    logic [BLOCK_W-1:0]    m_data_reg;
    logic                  m_last_reg;

    logic [8:0]            cur_sum;
    logic [COL_W-1:0]      draw_col;
    logic [CIDX_W-1:0]     col_idx;
    logic                  col_in;
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [7:0]            wdata;
    logic [ADDR_W-1:0]     raddr;
    logic [7:0]            hdr_byte;

    // configuration register, always ready
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= DEV_ADDR_RESET;
        end else if (cfg_valid) begin
            dev_addr_reg <= cfg_data;
        end
    end

    // cursor advance past glyph and gap, saturating at 255
    assign cur_sum = {1'b0, cur_col_reg} + DRAW_ADV;

    // cursor and request latches
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_page_reg <= '0;
            cur_col_reg  <= '0;
        end else if (cmd.set_cursor) begin
            cur_page_reg <= s_page;
            cur_col_reg  <= s_column;
        end else if (cmd.draw_step && sts.draw_last) begin
            cur_col_reg <= cur_sum[8] ? 8'hFF : cur_sum[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            char_reg       <= s_char_code;
            flush_page_reg <= s_page;
        end
    end

    // step counters for clear, draw, header and gather
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            draw_idx_reg <= '0;
            hdr_idx_reg  <= '0;
            blk_reg      <= '0;
            byte_reg     <= '0;
        end else begin
            if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.draw_step) begin
                draw_idx_reg <= sts.draw_last ? 3'd0 : draw_idx_reg + 3'd1;
            end
            if (cmd.flush_start) begin
                hdr_idx_reg <= HDR_PAGE;
                blk_reg     <= '0;
                byte_reg    <= '0;
            end else begin
                if (cmd.hdr_load) begin
                    hdr_idx_reg <= hdr_idx_reg + 2'd1;
                end
                if (cmd.rd_step) begin
                    byte_reg <= byte_reg + BYTE_IDX_W'(1);
                end
                if (cmd.data_load) begin
                    blk_reg <= blk_reg + BLK_W'(1);
                end
            end
        end
    end

    // store write port: clearing pass or glyph columns
    assign draw_col = cur_col_reg[COL_W-1:0] + COL_W'(draw_idx_reg);
    assign we       = cmd.clr_step | cmd.draw_step;
    assign waddr    = cmd.clr_step ? clr_cnt_reg : {cur_page_reg[PG_W-1:0], draw_col};
    assign wdata    = cmd.clr_step ? 8'h00 : glyph_column(char_reg, draw_idx_reg);

    // store read port for page flush
    assign col_idx = {blk_reg, byte_reg};
    assign col_in  = {1'b0, col_idx} < COL_LIMIT;
    assign raddr   = {flush_page_reg[PG_W-1:0], col_idx[COL_W-1:0]};

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // gather read bytes into a block, padding past the last column with zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.rd_step;
        end
    end

    always_ff @(posedge aclk) begin
        rd_in_reg <= col_in;
        if (rd_pend_reg) begin
            gather_reg <= {(rd_in_reg ? rdata_reg : 8'h00), gather_reg[BLOCK_W-1:8]};
        end
    end

    // header command byte
    always_comb begin
        case (hdr_idx_reg)
            HDR_PAGE:     hdr_byte = CMD_PAGE_BASE + {4'h0, flush_page_reg};
            HDR_COL_LOW:  hdr_byte = CMD_COL_LOW;
            HDR_COL_HIGH: hdr_byte = CMD_COL_HIGH;
            default:      hdr_byte = 8'h00;
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.hdr_load || cmd.data_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.hdr_load) begin
            m_is_data_reg <= 1'b0;
            m_cmd_reg     <= hdr_byte;
            m_data_reg    <= '0;
            m_last_reg    <= 1'b0;
        end else if (cmd.data_load) begin
            m_is_data_reg <= 1'b1;
            m_cmd_reg     <= 8'h00;
            m_data_reg    <= gather_reg;
            m_last_reg    <= (blk_reg == BLK_LAST);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_bus_address  = dev_addr_reg;
    assign m_is_data      = m_is_data_reg;
    assign m_command_byte = m_cmd_reg;
    assign m_data_low     = m_data_reg[63:0];
    assign m_data_high    = m_data_reg[127:64];
    assign m_last         = m_last_reg;

    // status to controller
    always_comb begin
        sts           = '0;
        sts.clr_done  = &clr_cnt_reg;
        sts.draw_ok   = ({1'b0, cur_page_reg} < PAGE_LIMIT) &&
                        ({1'b0, cur_col_reg} < DRAW_LIMIT);
        sts.draw_last = (draw_idx_reg == DRAW_LAST);
        sts.page_ok   = ({1'b0, s_page} < PAGE_LIMIT);
        sts.hdr_last  = (hdr_idx_reg == HDR_COL_HIGH);
        sts.byte_last = &byte_reg;
        sts.blk_last  = (blk_reg == BLK_LAST);
        sts.out_free  = !m_valid_reg || m_ready;
    end

endmodule

// ===== rtl/glyph_page_framebuffer_writer.sv =====
// top level of the glyph page framebuffer writer
//
// Text renderer into a page-organized monochrome display store.
// Requests arrive on the s_ channel (valid/ready): clear, set cursor,
// put character, flush page. Bus transactions leave on the m_ channel
// (valid/ready), one per transfer; cfg_valid/cfg_data writes the device
// address and is always ready.
// Work per request, after acceptance:
//   set cursor, or a put or flush out of range: no further steps
//   put character: six store writes, one column a cycle
//   clear: all 2^clog2(PAGE_COUNT)*2^clog2(COLUMN_COUNT) store bytes (1024 at
//     defaults) zeroed, one store byte written per cycle
//   flush: 3 header transactions, then per 16-byte block 16 store reads
//     through the single store read port, a wait state for the last read and
//     one load of the output register; longer if the receiver stalls
// Reset runs the same clearing pass as the clear request, s_ready low
// throughout it. A stalled receiver holds the output register; the flush
// waits, and once the last transaction sits in it a new request is taken.
module glyph_page_framebuffer_writer #(
    parameter int PAGE_COUNT   = gpfw_pkg::PAGE_COUNT_DEF,
    parameter int COLUMN_COUNT = gpfw_pkg::COLUMN_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [3:0]  s_page,
    input  logic [7:0]  s_column,
    input  logic [7:0]  s_char_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_bus_address,
    output logic        m_is_data,
    output logic [7:0]  m_command_byte,
    output logic [63:0] m_data_low,
    output logic [63:0] m_data_high,
    output logic        m_last
);
    import gpfw_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // sequencing
    gpfw_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .sts       (sts),
        .cmd       (cmd)
    );

    // store and transaction datapath
    gpfw_datapath #(
        .PAGE_COUNT   (PAGE_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_page         (s_page),
        .s_column       (s_column),
        .s_char_code    (s_char_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bus_address  (m_bus_address),
        .m_is_data      (m_is_data),
        .m_command_byte (m_command_byte),
        .m_data_low     (m_data_low),
        .m_data_high    (m_data_high),
        .m_last         (m_last)
    );

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the glyph page framebuffer writer
module testbench;
    import gpfw_pkg::*;

    localparam int PAGES = PAGE_COUNT_DEF;
    localparam int COLS  = COLUMN_COUNT_DEF;
    // a full clearing pass plus margin, the longest stretch with no result
    localparam int QUIET_CYCLES = 1100;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] page;
        logic [7:0] column;
        logic [7:0] char_code;
    } request_t;

    typedef struct packed {
        logic [6:0]  bus_address;
        logic        is_data;
        logic [7:0]  command_byte;
        logic [63:0] data_low;
        logic [63:0] data_high;
        logic        last;
    } bus_txn_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    logic [3:0]  s_page = '0;
    logic [7:0]  s_column = '0;
    logic [7:0]  s_char_code = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [6:0]  m_bus_address;
    logic        m_is_data;
    logic [7:0]  m_command_byte;
    logic [63:0] m_data_low;
    logic [63:0] m_data_high;
    logic        m_last;

    // shadow copy of the display store, cursor and bus address
    logic [7:0] shadow_store [PAGES][COLS];
    logic [3:0] shadow_page;
    logic [7:0] shadow_col;
    logic [6:0] shadow_addr;

    request_t pending_reqs [$];
    bus_txn_t expected_txns [$];
    request_t cur_req;
    bit       req_held = 1'b0;
    bit       steady = 1'b0;
    bit       stall_arm = 1'b0;
    bit       stall_done = 1'b0;
    int       stall_left = 0;
    int       fail_count = 0;
    int       queued = 0;

    glyph_page_framebuffer_writer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_page         (s_page),
        .s_column       (s_column),
        .s_char_code    (s_char_code),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bus_address  (m_bus_address),
        .m_is_data      (m_is_data),
        .m_command_byte (m_command_byte),
        .m_data_low     (m_data_low),
        .m_data_high    (m_data_high),
        .m_last         (m_last)
    );

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // 5x7 font, leftmost column in the top byte; blank for anything unknown
    function automatic logic [39:0] font_bits(input logic [7:0] code);
        logic [7:0] up;
        up = code;
        if (code >= "a" && code <= "z") begin
            up = code - 8'h20;
        end
        case (up)
            "0": return 40'h3E5149453E;
            "1": return 40'h00427F4000;
            "2": return 40'h6251494946;
            "3": return 40'h2249494936;
            "4": return 40'h1814127F10;
            "5": return 40'h2F49494931;
            "6": return 40'h3E49494932;
            "7": return 40'h0171090503;
            "8": return 40'h3649494936;
            "9": return 40'h264949493E;
            "A": return 40'h7E1111117E;
            "B": return 40'h7F49494936;
            "C": return 40'h3E41414122;
            "D": return 40'h7F4141221C;
            "E": return 40'h7F49494941;
            "F": return 40'h7F09090901;
            "G": return 40'h3E4149497A;
            "H": return 40'h7F0808087F;
            "I": return 40'h00417F4100;
            "J": return 40'h2040413F01;
            "K": return 40'h7F08142241;
            "L": return 40'h7F40404040;
            "M": return 40'h7F020C027F;
            "N": return 40'h7F0408107F;
            "O": return 40'h3E4141413E;
            "P": return 40'h7F09090906;
            "Q": return 40'h3E4151215E;
            "R": return 40'h7F09192946;
            "S": return 40'h4649494931;
            "T": return 40'h01017F0101;
            "U": return 40'h3F4040403F;
            "V": return 40'h1F2040201F;
            "W": return 40'h7F2018207F;
            "X": return 40'h6314081463;
            "Y": return 40'h0708700807;
            "Z": return 40'h6151494543;
            ":": return 40'h0036360000;
            ".": return 40'h0040600000;
            "-": return 40'h0808080808;
            "/": return 40'h2010080402;
            "+": return 40'h08083E0808;
            default: return 40'h0;
        endcase
    endfunction

    function automatic bus_txn_t bus_txn(input logic is_data, input logic [7:0] cmd,
                                         input logic [63:0] lo, input logic [63:0] hi,
                                         input logic last);
        bus_txn_t t;
        t.bus_address  = shadow_addr;
        t.is_data      = is_data;
        t.command_byte = cmd;
        t.data_low     = lo;
        t.data_high    = hi;
        t.last         = last;
        return t;
    endfunction

    // update the shadow state for one accepted request, queue its bus transactions
    task automatic apply_request(input request_t r);
        int          col;
        logic [39:0] g;
        logic [63:0] lo, hi;
        case (r.command)
            OP_CLEAR: begin
                for (int p = 0; p < PAGES; p++)
                    for (int c = 0; c < COLS; c++)
                        shadow_store[p][c] = 8'h00;
            end
            OP_CURSOR: begin
                shadow_page = r.page;
                shadow_col  = r.column;
            end
            OP_PUT: begin
                col = int'(shadow_col);
                if (shadow_page < PAGES && col < COLS - GLYPH_WIDTH) begin
                    g = font_bits(r.char_code);
                    for (int i = 0; i < GLYPH_WIDTH; i++) begin
                        if (col < COLS) begin
                            shadow_store[shadow_page][col] = g[39 - 8 * i -: 8];
                            col++;
                        end
                    end
                    // trailing blank column, clipped at the right edge
                    if (col < COLS) begin
                        shadow_store[shadow_page][col] = 8'h00;
                        col++;
                    end
                    shadow_col = (col > 255) ? 8'hFF : col[7:0];
                end
            end
            default: begin
                if (r.page < PAGES) begin
                    expected_txns.push_back(bus_txn(1'b0, CMD_PAGE_BASE + {4'h0, r.page},
                                                    '0, '0, 1'b0));
                    expected_txns.push_back(bus_txn(1'b0, CMD_COL_LOW, '0, '0, 1'b0));
                    expected_txns.push_back(bus_txn(1'b0, CMD_COL_HIGH, '0, '0, 1'b0));
                    for (int b = 0; b < (COLS + BLOCK_BYTES - 1) / BLOCK_BYTES; b++) begin
                        lo = '0;
                        hi = '0;
                        for (int j = 0; j < 8; j++) begin
                            if (b * BLOCK_BYTES + j < COLS)
                                lo[8 * j +: 8] = shadow_store[r.page][b * BLOCK_BYTES + j];
                            if (b * BLOCK_BYTES + 8 + j < COLS)
                                hi[8 * j +: 8] = shadow_store[r.page][b * BLOCK_BYTES + 8 + j];
                        end
                        expected_txns.push_back(bus_txn(1'b1, 8'h00, lo, hi,
                            (b + 1) * BLOCK_BYTES >= COLS));
                    end
                end
            end
        endcase
    endtask

    // request driver
    always @(posedge aclk) begin : req_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                apply_request(cur_req);
            end
            if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
                cur_req = pending_reqs.pop_front();
                req_held = 1'b1;
                s_valid <= 1'b1;
                s_command <= cur_req.command;
                s_page <= cur_req.page;
                s_column <= cur_req.column;
                s_char_code <= cur_req.char_code;
            end else begin
                req_held = 1'b0;
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver back-pressure
    always @(posedge aclk) begin : result_monitor
        bus_txn_t got, want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_bus_address, m_is_data, m_command_byte, m_data_low, m_data_high,
                       m_last};
                if (expected_txns.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transaction addr=%h data=%b cmd=%h lo=%h hi=%h last=%b",
                                 got.bus_address, got.is_data, got.command_byte,
                                 got.data_low, got.data_high, got.last);
                end else begin
                    want = expected_txns.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch exp addr=%h data=%b cmd=%h lo=%h hi=%h last=%b",
                                     want.bus_address, want.is_data, want.command_byte,
                                     want.data_low, want.data_high, want.last);
                            $display("         got addr=%h data=%b cmd=%h lo=%h hi=%h last=%b",
                                     got.bus_address, got.is_data, got.command_byte,
                                     got.data_low, got.data_high, got.last);
                        end
                    end
                end
            end
            // one long hold-off once armed, so the block backs up into its input
            if (stall_arm && !stall_done && m_valid) begin
                stall_left = HOLD_OFF_CYCLES;
                stall_done = 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
            end
            m_ready <= (stall_left == 0) && (steady || $urandom_range(99) >= 29);
        end
    end

    function automatic request_t mk_req(input logic [1:0] cmd, input logic [3:0] pg,
                                        input logic [7:0] col, input logic [7:0] ch);
        request_t r;
        r.command   = cmd;
        r.page      = pg;
        r.column    = col;
        r.char_code = ch;
        return r;
    endfunction

    task automatic queue_req(input request_t r);
        pending_reqs.push_back(r);
        queued++;
    endtask

    // mostly printable characters, with near misses and arbitrary codes
    function automatic logic [7:0] pick_char();
        logic [7:0] odd_codes [6] = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'h2C, 8'h3B};
        logic [7:0] symbols [6] = '{":", ".", "-", "/", "+", " "};
        case ($urandom_range(9))
            0, 1: return 8'($urandom_range(255));
            2, 3: return 8'(8'h30 + $urandom_range(9));
            4, 5: return 8'(8'h41 + $urandom_range(25));
            6, 7: return 8'(8'h61 + $urandom_range(25));
            8: return symbols[$urandom_range(5)];
            default: return odd_codes[$urandom_range(5)];
        endcase
    endfunction

    // text lines with optional flush, plus stray flushes, clears and noise
    task automatic random_traffic(input int count);
        int         target, sel, n;
        logic [3:0] pg;
        logic [7:0] col;
        target = queued + count;
        while (queued < target) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
                pg  = ($urandom_range(9) != 0) ? 4'($urandom_range(7))
                                               : 4'($urandom_range(15, 8));
                col = ($urandom_range(99) < 85) ? 8'($urandom_range(122))
                                                : 8'($urandom_range(255, 123));
                queue_req(mk_req(OP_CURSOR, pg, col, 8'($urandom_range(255))));
                n = $urandom_range(12, 1);
                repeat (n)
                    queue_req(mk_req(OP_PUT, 4'($urandom_range(15)), 8'($urandom_range(255)),
                                     pick_char()));
                if ($urandom_range(1))
                    queue_req(mk_req(OP_FLUSH, pg, 8'($urandom_range(255)),
                                     8'($urandom_range(255))));
            end else if (sel < 80) begin
                queue_req(mk_req(OP_FLUSH, 4'($urandom_range(15)), 8'($urandom_range(255)),
                                 8'($urandom_range(255))));
            end else if (sel < 83) begin
                queue_req(mk_req(OP_CLEAR, 4'($urandom_range(15)), 8'($urandom_range(255)),
                                 8'($urandom_range(255))));
            end else begin
                queue_req(mk_req(2'($urandom_range(3)), 4'($urandom_range(15)),
                                 8'($urandom_range(255)), 8'($urandom_range(255))));
            end
        end
    endtask

    // wait until every request is taken and every transaction seen, then let it drain
    task automatic settle();
        while (pending_reqs.size() != 0 || req_held || expected_txns.size() != 0)
            @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_address(input logic [6:0] addr);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= addr;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        shadow_addr = addr;
    endtask

    // run limit
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // stimulus sequence
    initial begin : stimulus
        for (int p = 0; p < PAGES; p++)
            for (int c = 0; c < COLS; c++)
                shadow_store[p][c] = 8'h00;
        shadow_page = '0;
        shadow_col  = '0;
        shadow_addr = DEV_ADDR_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // glyph classes from the reset cursor, at the reset bus address
        queue_req(mk_req(OP_PUT, 4'h0, 8'h00, "A"));
        queue_req(mk_req(OP_PUT, 4'hF, 8'hFF, "z"));
        queue_req(mk_req(OP_PUT, 4'h0, 8'h00, ":"));
        queue_req(mk_req(OP_PUT, 4'h0, 8'h00, "+"));
        queue_req(mk_req(OP_PUT, 4'h0, 8'h00, 8'hFF));
        queue_req(mk_req(OP_PUT, 4'h0, 8'h00, "."));
        // right edge: a put near it, one past it, then the last drawable position
        queue_req(mk_req(OP_CURSOR, 4'h0, 8'd120, 8'h00));
        queue_req(mk_req(OP_PUT, 4'h0, 8'h00, "8"));
        queue_req(mk_req(OP_PUT, 4'h0, 8'h00, "-"));
        queue_req(mk_req(OP_CURSOR, 4'h0, 8'd122, 8'h00));
        queue_req(mk_req(OP_PUT, 4'h0, 8'h00, "/"));
        // drawing off the store is ignored
        queue_req(mk_req(OP_CURSOR, 4'hF, 8'd3, 8'h00));
        queue_req(mk_req(OP_PUT, 4'h0, 8'h00, "Q"));
        queue_req(mk_req(OP_CURSOR, 4'h7, 8'hFF, 8'h00));
        queue_req(mk_req(OP_PUT, 4'h0, 8'h00, "Q"));
        // flushes, including missing pages
        queue_req(mk_req(OP_FLUSH, 4'h0, 8'h00, 8'h00));
        queue_req(mk_req(OP_FLUSH, 4'hF, 8'hFF, 8'hFF));
        queue_req(mk_req(OP_FLUSH, 4'h8, 8'h00, 8'h00));
        queue_req(mk_req(OP_CURSOR, 4'h7, 8'h00, 8'h00));
        queue_req(mk_req(OP_PUT, 4'h0, 8'h00, "9"));
        queue_req(mk_req(OP_PUT, 4'h0, 8'h00, " "));
        queue_req(mk_req(OP_FLUSH, 4'h7, 8'h00, 8'h00));
        queue_req(mk_req(OP_CLEAR, 4'h0, 8'h00, 8'h00));
        queue_req(mk_req(OP_FLUSH, 4'h0, 8'h00, 8'h00));
        settle();

        // lowest address, no idling on either side
        write_address(7'h00);
        steady = 1'b1;
        random_traffic(140);
        settle();
        steady = 1'b0;

        // highest address, receiver held off while flushes pile up
        write_address(7'h7F);
        stall_arm = 1'b1;
        for (int p = 0; p < PAGES; p++)
            queue_req(mk_req(OP_FLUSH, 4'(p), 8'($urandom_range(255)),
                             8'($urandom_range(255))));
        random_traffic(40);
        settle();

        // arbitrary address, random idling
        write_address(7'($urandom_range(127)));
        random_traffic(250);
        settle();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gpfw_pkg.sv
rtl/gpfw_ctrl.sv
rtl/gpfw_datapath.sv
rtl/glyph_page_framebuffer_writer.sv
dv/testbench.sv
